[hw/rtl/rhq_pkg.sv]
// Shared types and constants for the RGB to HSV palette quantizer.
// Holds register indexes, palette codes, hue sector offsets and divider sizing.
// No dependencies.
package rhq_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CfgHueFirst = 3'd0,
        CfgHueStep  = 3'd1,
        CfgGraySat  = 3'd2,
        CfgDarkVal  = 3'd3,
        CfgBright   = 3'd4
    } t_cfg_idx;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 8;

    // Register reset values
    localparam logic [7:0] HueFirstRst = 8'd21;
    localparam logic [7:0] HueStepRst  = 8'd41;
    localparam logic [7:0] GraySatRst  = 8'd40;
    localparam logic [7:0] DarkValRst  = 8'd40;
    localparam logic [7:0] BrightRst   = 8'd200;

    // Palette color codes (bits 2..0), bright flag is bit 3
    localparam logic [2:0] PalBlack   = 3'd0;
    localparam logic [2:0] PalRed     = 3'd1;
    localparam logic [2:0] PalGreen   = 3'd2;
    localparam logic [2:0] PalYellow  = 3'd3;
    localparam logic [2:0] PalBlue    = 3'd4;
    localparam logic [2:0] PalMagenta = 3'd5;
    localparam logic [2:0] PalCyan    = 3'd6;
    localparam logic [2:0] PalWhite   = 3'd7;

    // Gray level value bands
    localparam logic [7:0] GrayBand1 = 8'd65;
    localparam logic [7:0] GrayBand2 = 8'd130;
    localparam logic [7:0] GrayBand3 = 8'd200;

    // Hue sector offsets and scale factors
    localparam logic [7:0] HueOffRed   = 8'd0;
    localparam logic [7:0] HueOffGreen = 8'd85;
    localparam logic [7:0] HueOffBlue  = 8'd171;
    localparam logic [7:0] HueScale    = 8'd43;

    // Hue bins: six limits, the seventh bin catches the rest
    localparam int NumBins = 6;
    localparam int BinW = 3;
    localparam int LimW = 11;

    // Divider sizing: 16-bit dividend, 8-bit divisor and quotient
    localparam int DivNumW = 16;
    localparam int DivDenW = 8;
    localparam int DivQuoW = 8;
    localparam int DivStepBits = 2;
    localparam int DivStages = DivQuoW / DivStepBits;

    // Input capture, min/max, products, divider, hue/flags, output
    localparam int PipeLatency = DivStages + 5;

    typedef enum logic [1:0] {
        SecRed   = 2'd0,
        SecGreen = 2'd1,
        SecBlue  = 2'd2
    } t_sector;

    // Per-item fields that ride alongside the dividers
    typedef struct packed {
        logic       zero_span;
        logic       neg;
        t_sector    sector;
        logic [7:0] val;
    } t_side;

    // Map a hue bin to its palette color
    function automatic logic [2:0] bin_color(input logic [BinW-1:0] bin);
        logic [2:0] c;
        case (bin)
            3'd0:    c = PalRed;
            3'd1:    c = PalYellow;
            3'd2:    c = PalGreen;
            3'd3:    c = PalCyan;
            3'd4:    c = PalBlue;
            3'd5:    c = PalMagenta;
            default: c = PalRed;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/rgb_to_hsv_palette16_quantizer.sv]
// RGB to HSV converter with 16-color console palette quantizer, top level.
// Depends on rhq_pkg and rhq_div.
//
// Usage:
//   Input: drive i_red_in, i_green_in, i_blue_in with start high; the pixel is
//   transferred at a rising edge where start is high and busy is low. busy is
//   high only during reset and in the first cycle after it, so one pixel can be taken every
//   clock after that.
//   Output: o_valid marks one result for exactly one cycle, with o_hue_out,
//   o_sat_out, o_val_out and o_color_code. The receiver cannot stall.
//   Pipeline: after the transfer edge the pixel passes the capture, min/max,
//   products, four divider stages, hue and compares, and palette code
//   registers before o_valid. Throughput: one pixel per clock, set by the fully
//   pipelined dividers, which resolve two quotient bits per stage.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 hue_first_limit, 1 hue_step, 2 gray_sat_limit, 3 dark_value_limit,
//   4 bright_limit); other indexes are dropped. Write only while idle.
//   Reset: synchronous, active low; clears in-flight valid bits and loads
//   the register defaults.
module rgb_to_hsv_palette16_quantizer
    import rhq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [7:0]          i_red_in,
    input  logic [7:0]          i_green_in,
    input  logic [7:0]          i_blue_in,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output logic                o_valid,
    output logic [7:0]          o_hue_out,
    output logic [7:0]          o_sat_out,
    output logic [7:0]          o_val_out,
    output logic [3:0]          o_color_code
);

    // Configuration registers and derived bin limits
    logic [7:0]      r_hue_first, r_hue_step, r_gray_sat, r_dark_val, r_bright;
    logic [LimW-1:0] r_lim [NumBins];
    logic            r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_first <= HueFirstRst;
            r_hue_step  <= HueStepRst;
            r_gray_sat  <= GraySatRst;
            r_dark_val  <= DarkValRst;
            r_bright    <= BrightRst;
            r_run       <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CfgHueFirst: r_hue_first <= i_cfg_data;
                    CfgHueStep:  r_hue_step  <= i_cfg_data;
                    CfgGraySat:  r_gray_sat  <= i_cfg_data;
                    CfgDarkVal:  r_dark_val  <= i_cfg_data;
                    CfgBright:   r_bright    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Bin limits, computed without wrap
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NumBins; i++) begin
            r_lim[i] <= LimW'(r_hue_first) + LimW'(r_hue_step) * LimW'(i);
        end
    end

    assign busy = !r_run;

    // Stage A: capture the pixel
    logic       r_a_valid;
    logic [7:0] r_a_r, r_a_g, r_a_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_r <= i_red_in;
        r_a_g <= i_green_in;
        r_a_b <= i_blue_in;
    end

    // Stage B: max, min, span, sector and hue difference
    logic       n_b_neg;
    logic [7:0] n_b_max, n_b_min, n_b_abs, w_dx, w_dy;
    t_sector    n_b_sec;

    always_comb begin
        n_b_max = (r_a_r > r_a_g) ? r_a_r : r_a_g;
        n_b_max = (n_b_max > r_a_b) ? n_b_max : r_a_b;
        n_b_min = (r_a_r < r_a_g) ? r_a_r : r_a_g;
        n_b_min = (n_b_min < r_a_b) ? n_b_min : r_a_b;
        if (n_b_max == r_a_r) begin
            n_b_sec = SecRed;
            w_dx    = r_a_g;
            w_dy    = r_a_b;
        end else if (n_b_max == r_a_g) begin
            n_b_sec = SecGreen;
            w_dx    = r_a_b;
            w_dy    = r_a_r;
        end else begin
            n_b_sec = SecBlue;
            w_dx    = r_a_r;
            w_dy    = r_a_g;
        end
        n_b_neg = w_dx < w_dy;
        n_b_abs = n_b_neg ? (w_dy - w_dx) : (w_dx - w_dy);
    end

    logic       r_b_valid, r_b_neg;
    logic [7:0] r_b_max, r_b_span, r_b_abs;
    t_sector    r_b_sec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_max  <= n_b_max;
        r_b_span <= n_b_max - n_b_min;
        r_b_abs  <= n_b_abs;
        r_b_neg  <= n_b_neg;
        r_b_sec  <= n_b_sec;
    end

    // Stage C: scaled dividends for saturation and hue
    logic                r_c_valid;
    logic [DivNumW-1:0]  r_c_num_s, r_c_num_h;
    logic [DivDenW-1:0]  r_c_span;
    t_side               r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_num_s          <= {r_b_span, 8'd0} - DivNumW'(r_b_span);
        r_c_num_h          <= DivNumW'(r_b_abs) * DivNumW'(HueScale);
        r_c_span           <= r_b_span;
        r_c_side.zero_span <= (r_b_span == 8'd0);
        r_c_side.neg       <= r_b_neg;
        r_c_side.sector    <= r_b_sec;
        r_c_side.val       <= r_b_max;
    end

    // Dividers: saturation = 255*span/max, hue term = 43*|diff|/span
    logic [DivQuoW-1:0] w_quo_s, w_quo_h;

    rhq_div #(
        .NUM_W     (DivNumW),
        .DEN_W     (DivDenW),
        .QUO_W     (DivQuoW),
        .STEP_BITS (DivStepBits)
    ) u_div_sat (
        .i_clk (i_clk),
        .i_num (r_c_num_s),
        .i_den (r_c_side.val),
        .o_quo (w_quo_s)
    );

    rhq_div #(
        .NUM_W     (DivNumW),
        .DEN_W     (DivDenW),
        .QUO_W     (DivQuoW),
        .STEP_BITS (DivStepBits)
    ) u_div_hue (
        .i_clk (i_clk),
        .i_num (r_c_num_h),
        .i_den (r_c_span),
        .o_quo (w_quo_h)
    );

    // Carry valid and side fields alongside the divider stages
    logic  r_d_valid [DivStages];
    t_side r_d_side  [DivStages];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DivStages; i++) begin
                r_d_valid[i] <= 1'b0;
            end
        end else begin
            r_d_valid[0] <= r_c_valid;
            for (int i = 1; i < DivStages; i++) begin
                r_d_valid[i] <= r_d_valid[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_side[0] <= r_c_side;
        for (int i = 1; i < DivStages; i++) begin
            r_d_side[i] <= r_d_side[i-1];
        end
    end

    // Stage E: hue, saturation and palette compares
    t_side              w_e_side;
    logic [7:0]         n_e_hue, n_e_sat, w_off, w_term;
    logic [8:0]         w_sum;
    logic [3:0]         n_e_gray_code;
    logic [NumBins-1:0] n_e_le;

    assign w_e_side = r_d_side[DivStages-1];

    always_comb begin
        case (w_e_side.sector)
            SecRed:   w_off = HueOffRed;
            SecGreen: w_off = HueOffGreen;
            SecBlue:  w_off = HueOffBlue;
            default:  w_off = HueOffRed;
        endcase
        // Quotient truncates toward zero, so negate after dividing
        w_term  = w_e_side.neg ? (~w_quo_h + 8'd1) : w_quo_h;
        n_e_hue = w_e_side.zero_span ? 8'd0 : (w_off + w_term);
        n_e_sat = w_e_side.zero_span ? 8'd0 : w_quo_s;
        w_sum   = 9'(n_e_sat) + 9'(w_e_side.val);
        if (w_e_side.val < GrayBand1) begin
            n_e_gray_code = {1'b0, PalBlack};
        end else if (w_e_side.val < GrayBand2) begin
            n_e_gray_code = {1'b1, PalBlack};
        end else if (w_e_side.val < GrayBand3) begin
            n_e_gray_code = {1'b0, PalWhite};
        end else begin
            n_e_gray_code = {1'b1, PalWhite};
        end
        for (int i = 0; i < NumBins; i++) begin
            n_e_le[i] = LimW'(n_e_hue) <= r_lim[i];
        end
    end

    logic               r_e_valid, r_e_gray, r_e_bright, r_e_dark;
    logic [7:0]         r_e_hue, r_e_sat, r_e_val;
    logic [3:0]         r_e_gray_code;
    logic [NumBins-1:0] r_e_le;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= r_d_valid[DivStages-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_hue       <= n_e_hue;
        r_e_sat       <= n_e_sat;
        r_e_val       <= w_e_side.val;
        r_e_gray      <= n_e_sat < r_gray_sat;
        r_e_bright    <= w_sum[8:1] > r_bright;
        r_e_dark      <= w_e_side.val < r_dark_val;
        r_e_gray_code <= n_e_gray_code;
        r_e_le        <= n_e_le;
    end

    // Stage F: pick the first matching bin and form the code
    logic [BinW-1:0] w_bin;
    logic [3:0]      n_code;

    always_comb begin
        w_bin = BinW'(NumBins);
        for (int i = NumBins - 1; i >= 0; i--) begin
            if (r_e_le[i]) begin
                w_bin = BinW'(i);
            end
        end
        if (r_e_gray) begin
            n_code = r_e_gray_code;
        end else begin
            n_code = {r_e_bright, bin_color(w_bin)};
        end
        if (r_e_dark) begin
            n_code = {1'b0, PalBlack};
        end
    end

    logic       r_o_valid;
    logic [7:0] r_o_hue, r_o_sat, r_o_val;
    logic [3:0] r_o_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_hue  <= r_e_hue;
        r_o_sat  <= r_e_sat;
        r_o_val  <= r_e_val;
        r_o_code <= n_code;
    end

    assign o_valid      = r_o_valid;
    assign o_hue_out    = r_o_hue;
    assign o_sat_out    = r_o_sat;
    assign o_val_out    = r_o_val;
    assign o_color_code = r_o_code;

    // Every result traces back to a transfer a fixed latency earlier
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PipeLatency))
        else $error("result without a matching input transfer");

    // A dark value always forces black
    a_dark_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_val_out < r_dark_val)) |-> (o_color_code == {1'b0, PalBlack}))
        else $error("dark pixel not mapped to black");

    // Black pixel has zero hue and saturation
    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_val_out == 8'd0)) |-> (o_sat_out == 8'd0 && o_hue_out == 8'd0))
        else $error("black pixel with nonzero hue or saturation");

    // Zero saturation means an achromatic pixel with zero hue
    a_gray_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_sat_out == 8'd0)) |-> (o_hue_out == 8'd0))
        else $error("zero saturation with nonzero hue");

endmodule

[hw/rtl/rhq_div.sv]
// Pipelined restoring divider, STEP_BITS quotient bits per register stage.
// Quotient must fit in QUO_W bits; payload only, no valid tracking here.
// No dependencies.
module rhq_div #(
    parameter int NUM_W     = 16,
    parameter int DEN_W     = 8,
    parameter int QUO_W     = 8,
    parameter int STEP_BITS = 2
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    localparam int STAGES = QUO_W / STEP_BITS;
    localparam int EXT_W  = NUM_W + QUO_W;

    logic [NUM_W-1:0] r_rem [STAGES];
    logic [DEN_W-1:0] r_den [STAGES];
    logic [QUO_W-1:0] r_quo [STAGES];

    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        logic [NUM_W-1:0] w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [QUO_W-1:0] w_quo_in;
        logic [NUM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_quo;

        // Select stage input
        if (j == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_den_in = r_den[j-1];
            assign w_quo_in = r_quo[j-1];
        end

        // Resolve STEP_BITS quotient bits, most significant first
        always_comb begin
            logic [EXT_W-1:0] trial;
            n_rem = w_rem_in;
            n_quo = w_quo_in;
            for (int b = 0; b < STEP_BITS; b++) begin
                trial = EXT_W'(w_den_in) << (QUO_W - 1 - j * STEP_BITS - b);
                if (EXT_W'(n_rem) >= trial) begin
                    n_rem = n_rem - NUM_W'(trial);
                    n_quo[QUO_W - 1 - j * STEP_BITS - b] = 1'b1;
                end
            end
        end

        // Advance one stage
        always_ff @(posedge i_clk) begin
            r_rem[j] <= n_rem;
            r_den[j] <= w_den_in;
            r_quo[j] <= n_quo;
        end
    end

    assign o_quo = r_quo[STAGES-1];

endmodule

[test/tb_rgb_to_hsv_palette16_quantizer.sv]
// Testbench for rgb_to_hsv_palette16_quantizer: pixel stimulus, register settings and checking.
// Depends on rhq_pkg and the rgb_to_hsv_palette16_quantizer RTL; nothing else.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_palette16_quantizer;
    import rhq_pkg::*;

    localparam logic [3:0] BrightFlag = 4'h8;
    localparam int WatchdogLimit = 500;
    localparam int PhaseCount = 10;
    localparam int PixelsPerPhase = 133;

    // One converted pixel: HSV plus console color
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        logic [3:0] color;
    } t_hsv_pix;

    // Predicts each pixel's HSV and color, and checks results in order
    class hsv_scoreboard;
        t_hsv_pix   expected_q[$];
        logic [7:0] hue_first;
        logic [7:0] hue_step;
        logic [7:0] gray_limit;
        logic [7:0] dark_limit;
        logic [7:0] bright_limit;
        int         pixels_in;
        int         results_in;
        int         fail_count;

        function new();
            hue_first    = HueFirstRst;
            hue_step     = HueStepRst;
            gray_limit   = GraySatRst;
            dark_limit   = DarkValRst;
            bright_limit = BrightRst;
            pixels_in    = 0;
            results_in   = 0;
            fail_count   = 0;
        endfunction

        // Mirror a register write; unknown indexes are dropped
        function void set_reg(logic [CfgIdxW-1:0] idx, logic [7:0] data);
            case (t_cfg_idx'(idx))
                CfgHueFirst: hue_first = data;
                CfgHueStep:  hue_step = data;
                CfgGraySat:  gray_limit = data;
                CfgDarkVal:  dark_limit = data;
                CfgBright:   bright_limit = data;
                default: ;
            endcase
        endfunction

        function t_hsv_pix hsv_of_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int       ri, gi, bi, mx, mn, span, diff, off, hue, sat, bin, i;
            logic [2:0] base;
            t_hsv_pix res;
            ri = r;
            gi = g;
            bi = b;
            mx = (ri > gi) ? ri : gi;
            mx = (mx > bi) ? mx : bi;
            mn = (ri < gi) ? ri : gi;
            mn = (mn < bi) ? mn : bi;
            hue = 0;
            sat = 0;
            // Saturation and sector hue; integer division truncates toward zero
            if (mx != 0) begin
                sat = (255 * (mx - mn)) / mx;
                if (sat != 0) begin
                    span = mx - mn;
                    if (mx == ri) begin
                        off = int'(HueOffRed);
                        diff = gi - bi;
                    end else if (mx == gi) begin
                        off = int'(HueOffGreen);
                        diff = bi - ri;
                    end else begin
                        off = int'(HueOffBlue);
                        diff = ri - gi;
                    end
                    hue = (off + (int'(HueScale) * diff) / span) & 255;
                end
            end
            res.hue = 8'(hue);
            res.sat = 8'(sat);
            res.val = 8'(mx);
            // Gray levels at low saturation, hue bins otherwise
            if (sat < int'(gray_limit)) begin
                if (mx < int'(GrayBand1))      res.color = {1'b0, PalBlack};
                else if (mx < int'(GrayBand2)) res.color = BrightFlag | {1'b0, PalBlack};
                else if (mx < int'(GrayBand3)) res.color = {1'b0, PalWhite};
                else                           res.color = BrightFlag | {1'b0, PalWhite};
            end else begin
                bin = NumBins;
                for (i = 0; i < NumBins; i++) begin
                    if (bin == NumBins && hue <= int'(hue_first) + i * int'(hue_step))
                        bin = i;
                end
                case (bin)
                    0:       base = PalRed;
                    1:       base = PalYellow;
                    2:       base = PalGreen;
                    3:       base = PalCyan;
                    4:       base = PalBlue;
                    5:       base = PalMagenta;
                    default: base = PalRed;
                endcase
                res.color = {1'b0, base};
                if (((sat + mx) >> 1) > int'(bright_limit)) res.color |= BrightFlag;
            end
            // Dark value wins over everything
            if (mx < int'(dark_limit)) res.color = {1'b0, PalBlack};
            return res;
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            pixels_in++;
            expected_q.push_back(hsv_of_pixel(r, g, b));
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                fail_count++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(t_hsv_pix got);
            t_hsv_pix want;
            results_in++;
            if (expected_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result: expected none, actual h=%0d s=%0d v=%0d c=%0d",
                         $time, got.hue, got.sat, got.val, got.color);
                return;
            end
            want = expected_q.pop_front();
            compare_field("hue", want.hue, got.hue);
            compare_field("sat", want.sat, got.sat);
            compare_field("val", want.val, got.val);
            compare_field("color", {4'h0, want.color}, {4'h0, got.color});
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [7:0]         i_red_in = '0;
    logic [7:0]         i_green_in = '0;
    logic [7:0]         i_blue_in = '0;
    logic               i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [7:0]         i_cfg_data = '0;
    logic               o_valid;
    logic [7:0]         o_hue_out;
    logic [7:0]         o_sat_out;
    logic [7:0]         o_val_out;
    logic [3:0]         o_color_code;

    hsv_scoreboard sb;
    int            seen_transfers = 0;
    int            stall_cycles = 0;

    rgb_to_hsv_palette16_quantizer u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_hue_out    (o_hue_out),
        .o_sat_out    (o_sat_out),
        .o_val_out    (o_val_out),
        .o_color_code (o_color_code)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check every strobed result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            sb.check_result({o_hue_out, o_sat_out, o_val_out, o_color_code});
    end

    // End the run when neither side transfers anything for too long
    always @(posedge i_clk) begin
        if (sb.pixels_in + sb.results_in != seen_transfers) begin
            seen_transfers <= sb.pixels_in + sb.results_in;
            stall_cycles <= 0;
        end else if (stall_cycles >= WatchdogLimit) begin
            $display("%0t: watchdog expired with %0d results outstanding", $time, sb.pending());
            $display("** rgb_to_hsv_palette16_quantizer: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one pixel and hold it until transferred; start stays high
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        start <= 1'b1;
        i_red_in <= r;
        i_green_in <= g;
        i_blue_in <= b;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_pixel(r, g, b);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // Program one register setting per phase: extremes first, defaults last
    task automatic load_settings(input int phase);
        logic [7:0] first, step, gray, dark, bright;
        if (phase == 1) begin
            first = 8'd0; step = 8'd0; gray = 8'd0; dark = 8'd0; bright = 8'd0;
        end else if (phase == 2) begin
            first = 8'd255; step = 8'd255; gray = 8'd255; dark = 8'd255; bright = 8'd255;
        end else if (phase == 3) begin
            first = 8'd0; step = 8'd1; gray = 8'd1; dark = 8'd0; bright = 8'd255;
        end else if (phase == PhaseCount) begin
            first = HueFirstRst; step = HueStepRst; gray = GraySatRst;
            dark = DarkValRst; bright = BrightRst;
        end else begin
            first = 8'($urandom);
            step = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(60, 1));
            gray = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(80));
            dark = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(80));
            bright = 8'($urandom_range(255, 100));
        end
        write_reg(CfgHueFirst, first);
        write_reg(CfgHueStep, step);
        write_reg(CfgGraySat, gray);
        write_reg(CfgDarkVal, dark);
        write_reg(CfgBright, bright);
        // Unknown index must leave every register alone
        write_reg(CfgIdxW'($urandom_range((1 << CfgIdxW) - 1, int'(CfgBright) + 1)),
                  8'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Mix of uniform, near-gray, saturated and extreme pixels
    task automatic pick_pixel(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
        int kind, base;
        kind = $urandom_range(9);
        if (kind < 3) begin
            r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        end else if (kind < 5) begin
            base = $urandom_range(255);
            r = 8'(base ^ $urandom_range(15));
            g = 8'(base ^ $urandom_range(15));
            b = 8'(base ^ $urandom_range(15));
        end else if (kind < 8) begin
            r = 8'($urandom);
            g = 8'($urandom_range(255, 128));
            b = 8'($urandom_range(8));
            case ($urandom_range(2))
                0: {r, g, b} = {g, b, r};
                1: {r, g, b} = {b, r, g};
                default: ;
            endcase
        end else begin
            r = ($urandom_range(1) == 0) ? 8'($urandom_range(1)) : 8'($urandom_range(255, 254));
            g = ($urandom_range(1) == 0) ? 8'($urandom_range(1)) : 8'($urandom_range(255, 254));
            b = ($urandom_range(1) == 0) ? 8'($urandom_range(1)) : 8'($urandom_range(255, 254));
        end
    endtask

    initial begin
        int         phase;
        int         n;
        int         idle_pct;
        logic [7:0] r, g, b;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels under the default registers
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd200);
        send_pixel(8'd30, 8'd10, 8'd5);
        send_pixel(8'd100, 8'd95, 8'd90);
        send_pixel(8'd64, 8'd64, 8'd64);
        send_pixel(8'd65, 8'd65, 8'd65);
        send_pixel(8'd129, 8'd129, 8'd129);
        send_pixel(8'd130, 8'd130, 8'd130);
        send_pixel(8'd199, 8'd199, 8'd199);
        send_pixel(8'd200, 8'd200, 8'd200);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd39, 8'd0, 8'd0);
        send_pixel(8'd40, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd200, 8'd0);
        send_pixel(8'd10, 8'd255, 8'd9);

        // Random pixels, one register setting per phase
        for (phase = 1; phase <= PhaseCount; phase++) begin
            drain_results();
            load_settings(phase);
            idle_pct = (phase == PhaseCount) ? 0 : 12 * $urandom_range(3);
            for (n = 0; n < PixelsPerPhase; n++) begin
                pick_pixel(r, g, b);
                send_pixel(r, g, b);
                if ($urandom_range(99) < idle_pct) begin
                    start <= 1'b0;
                    repeat ($urandom_range(9, 1)) @(posedge i_clk);
                end
            end
        end

        drain_results();
        repeat (2 * PipeLatency) @(posedge i_clk);

        $display("Converted %0d pixels under %0d register settings, %0d results checked.",
                 sb.pixels_in, PhaseCount + 1, sb.results_in);
        $display("Pixels covered gray, dark, saturated and extreme channels with random stalls.");
        if (sb.pending() != 0) begin
            sb.fail_count++;
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        if (sb.fail_count == 0)
            $display("** rgb_to_hsv_palette16_quantizer: PASSED **");
        else
            $display("** rgb_to_hsv_palette16_quantizer: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/rhq_pkg.sv
hw/rtl/rhq_div.sv
hw/rtl/rgb_to_hsv_palette16_quantizer.sv
test/tb_rgb_to_hsv_palette16_quantizer.sv
